// ===== design/slcd_pkg.sv =====
// Shared types, keyword table and codes for the serial line command decoder.
package slcd_pkg;

  localparam int KW_NUM     = 18;
  localparam int KW_MAX_LEN = 12;

  // Keyword slots: slot 0 is STOP, slots 1..16 the table, slot 17 HELLO.
  // Command code of slot k is k + 1.
  localparam logic [4:0] KW_IDX_STOP  = 5'd0;
  localparam logic [4:0] KW_IDX_HELLO = 5'd17;
  localparam int         KW_TBL_FIRST = 1;
  localparam int         KW_TBL_LAST  = 16;

  localparam logic [4:0] CODE_NONE  = 5'd0;
  localparam logic [4:0] CODE_STOP  = 5'd1;
  localparam logic [4:0] CODE_HELLO = 5'd18;
  localparam logic [4:0] CODE_EVENT_MAX = 5'd17;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_BUSY    = 2'd2,
    KIND_INVALID = 2'd3
  } ack_kind_t;

  typedef logic [8*KW_MAX_LEN-1:0] kw_text_t;

  // Text is right-justified: the last character sits in the low byte.
  localparam kw_text_t KW_TEXT [KW_NUM] = '{
    kw_text_t'("STOP"),
    kw_text_t'("AUTO"),
    kw_text_t'("MANUAL"),
    kw_text_t'("FORWARD"),
    kw_text_t'("BACKWARD"),
    kw_text_t'("LEFT"),
    kw_text_t'("RIGHT"),
    kw_text_t'({"ROTATE", "_CW"}),
    kw_text_t'({"ROTATE", "_CCW"}),
    kw_text_t'({"SERVO", "_DOOR"}),
    kw_text_t'({"SERVO", "_CAMERA"}),
    kw_text_t'({"SERVO", "_BUCKET"}),
    kw_text_t'({"SERVO", "_BRUSH"}),
    kw_text_t'({"SET", "_HOME"}),
    kw_text_t'("ROTATE180"),
    kw_text_t'("ROTATE360"),
    kw_text_t'("STATUS"),
    kw_text_t'("HELLO")
  };

  localparam logic [3:0] KW_LEN [KW_NUM] = '{
    4'd4, 4'd4, 4'd6, 4'd7, 4'd8, 4'd4, 4'd5, 4'd9, 4'd10,
    4'd10, 4'd12, 4'd12, 4'd11, 4'd8, 4'd9, 4'd9, 4'd6, 4'd5
  };

  typedef struct packed {
    ack_kind_t   kind;
    logic [4:0]  cmd;
    logic [4:0]  taken;
    logic [31:0] valid_total;
    logic [31:0] invalid_total;
  } res_t;

  // Character at position p of keyword slot k (p below the keyword length).
  function automatic logic [7:0] kw_char(input logic [4:0] k, input logic [3:0] p);
    logic [3:0] b;
    b = KW_LEN[k] - 4'd1 - p;
    return KW_TEXT[k][{b, 3'b000} +: 8];
  endfunction

endpackage

// ===== design/slcd_if.sv =====
// Valid/ready channel interfaces for request and result transfers.
interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface slcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  ack_kind;
  logic [4:0]  ack_command;
  logic [4:0]  taken_event;
  logic [31:0] valid_total;
  logic [31:0] invalid_total;

  modport source (output valid, output ack_kind, output ack_command, output taken_event,
                  output valid_total, output invalid_total, input ready);
  modport sink   (input valid, input ack_kind, input ack_command, input taken_event,
                  input valid_total, input invalid_total, output ready);
endinterface

// ===== design/slcd_core.sv =====
// Line state, per-keyword match flags, pending event and counters.
module slcd_core import slcd_pkg::*; #(
  parameter int LINE_CAPACITY = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  output res_t       res
);

  localparam int LW = $clog2(LINE_CAPACITY);
  localparam logic [LW-1:0] LEN_LAST = LW'(LINE_CAPACITY - 1);

  logic [LW-1:0]     len_r, len_nxt;
  logic [KW_NUM-1:0] flag_r, flag_nxt;   // line so far is a prefix of keyword
  logic [KW_NUM-1:0] cr_r, cr_nxt;       // line is keyword followed by CR
  logic [4:0]        pend_r, pend_nxt;
  logic [31:0]       vcnt_r, vcnt_nxt;
  logic [31:0]       icnt_r, icnt_nxt;

  logic [KW_NUM-1:0] hit;
  logic [KW_NUM-1:0] flag_app, cr_app;
  logic              tbl_hit;
  logic [4:0]        tbl_code;

  always_comb begin
    tbl_hit  = 1'b0;
    tbl_code = CODE_NONE;
    for (int k = 0; k < KW_NUM; k++) begin
      hit[k]      = (flag_r[k] && len_r == LW'(KW_LEN[k])) || cr_r[k];
      flag_app[k] = flag_r[k] && (len_r < LW'(KW_LEN[k]))
                    && (rx_byte == kw_char(5'(k), len_r[3:0]));
      cr_app[k]   = flag_r[k] && (len_r == LW'(KW_LEN[k])) && (rx_byte == CHAR_CR);
    end
    for (int k = KW_TBL_FIRST; k <= KW_TBL_LAST; k++) begin
      if (hit[k]) begin
        tbl_hit  = 1'b1;
        tbl_code = tbl_code | 5'(k + 1);
      end
    end
  end

  always_comb begin
    len_nxt  = len_r;
    flag_nxt = flag_r;
    cr_nxt   = cr_r;
    pend_nxt = pend_r;
    vcnt_nxt = vcnt_r;
    icnt_nxt = icnt_r;
    res.kind  = KIND_NONE;
    res.cmd   = CODE_NONE;
    res.taken = CODE_NONE;

    if (req_type) begin
      res.taken = pend_r;
      pend_nxt  = CODE_NONE;
    end else if (rx_byte == CHAR_LF) begin
      len_nxt  = '0;
      flag_nxt = '1;
      cr_nxt   = '0;
      priority if (hit[KW_IDX_STOP]) begin
        pend_nxt  = CODE_STOP;
        vcnt_nxt  = vcnt_r + 32'd1;
        res.kind  = KIND_ACCEPT;
        res.cmd   = CODE_STOP;
      end else if (hit[KW_IDX_HELLO]) begin
        vcnt_nxt  = vcnt_r + 32'd1;
        res.kind  = KIND_ACCEPT;
        res.cmd   = CODE_HELLO;
      end else if (tbl_hit) begin
        if (pend_r != CODE_NONE) begin
          res.kind = KIND_BUSY;
        end else begin
          pend_nxt = tbl_code;
          vcnt_nxt = vcnt_r + 32'd1;
          res.kind = KIND_ACCEPT;
          res.cmd  = tbl_code;
        end
      end else begin
        icnt_nxt = icnt_r + 32'd1;
        res.kind = KIND_INVALID;
      end
    end else if (len_r < LEN_LAST) begin
      len_nxt  = len_r + LW'(1);
      flag_nxt = flag_app;
      cr_nxt   = cr_app;
    end else begin
      // overlong line: drop it, no acknowledge
      len_nxt  = '0;
      flag_nxt = '1;
      cr_nxt   = '0;
      icnt_nxt = icnt_r + 32'd1;
    end

    res.valid_total   = vcnt_nxt;
    res.invalid_total = icnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r  <= '0;
      flag_r <= '1;
      cr_r   <= '0;
      pend_r <= CODE_NONE;
      vcnt_r <= '0;
      icnt_r <= '0;
    end else if (fire) begin
      len_r  <= len_nxt;
      flag_r <= flag_nxt;
      cr_r   <= cr_nxt;
      pend_r <= pend_nxt;
      vcnt_r <= vcnt_nxt;
      icnt_r <= icnt_nxt;
    end
  end

  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= CODE_EVENT_MAX)
    else $error("pending event out of range");

  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_LAST)
    else $error("line length past capacity");

  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && req_type |=> pend_r == CODE_NONE)
    else $error("take request left an event pending");

endmodule

// ===== design/slcd_outq.sv =====
// Two-entry result queue between the decoder and the result channel.
module slcd_outq import slcd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t din,
  output logic full,
  output logic dvalid,
  output res_t dout,
  input  logic pop
);

  res_t       mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign full   = (cnt_r == 2'd2);
  assign dvalid = (cnt_r != 2'd0);
  assign dout   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count corrupt");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("push lost");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("push into full queue");

endmodule

// ===== design/serial_line_command_decoder_unit.sv =====
// Top level of the serial line command decoder.
//
//  channel | dir | payload                                         | transfer when
//  in_ch   | in  | req_type, rx_byte                               | valid & ready
//  out_ch  | out | ack_kind, ack_command, taken_event, totals      | valid & ready
//
// One item per cycle unless the queue is full: each accepted request updates
// the match flags and counters in the same cycle and queues one result.
// The limit is the single-pass decode between the line state and the queue.
// Reset (rst_n low, synchronous) empties the line, clears the pending event,
// zeroes both totals and flushes the result queue.
// A stalled result channel is absorbed by a two-entry queue; in_ch.ready
// is low during reset and while both entries are held.
module serial_line_command_decoder_unit import slcd_pkg::*; #(
  parameter int LINE_CAPACITY = 32
) (
  input logic        clk,
  input logic        rst_n,
  slcd_in_if.sink    in_ch,
  slcd_out_if.source out_ch
);

  logic fire;      // request transfer
  logic pop;       // result transfer
  logic q_full;
  logic q_valid;
  res_t core_res;
  res_t q_res;

  // no transfer is taken while reset holds the line state and queue
  assign in_ch.ready = rst_n && !q_full;
  assign fire        = in_ch.valid && in_ch.ready;
  assign pop         = q_valid && out_ch.ready;

  // match flags, pending event and totals advance on every request transfer
  slcd_core #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .req_type (in_ch.req_type),
    .rx_byte  (in_ch.rx_byte),
    .res      (core_res)
  );

  // result register plus skid entry
  slcd_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (fire),
    .din    (core_res),
    .full   (q_full),
    .dvalid (q_valid),
    .dout   (q_res),
    .pop    (pop)
  );

  assign out_ch.valid         = q_valid;
  assign out_ch.ack_kind      = q_res.kind;
  assign out_ch.ack_command   = q_res.cmd;
  assign out_ch.taken_event   = q_res.taken;
  assign out_ch.valid_total   = q_res.valid_total;
  assign out_ch.invalid_total = q_res.invalid_total;

endmodule
